[rtl/kxrf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kxrf_pkg
// shared constants and types for the keyed xor record framer
// ----------------------------------------------------------------------------
package kxrf_pkg;

   localparam int KEY_MAX_BYTES_DEF = 32;

   // record layout
   localparam int SIG_BYTES  = 8;
   localparam int HDR_BYTES  = 12;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD_3 = 3'd5;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // decode status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIG   = 2'd2;
   localparam logic [1:0] STATUS_OVERRUN   = 2'd3;

   // emit sequence: steps 0..11 are header bytes, then data, then status
   localparam logic [3:0] STEP_HDR_FIRST = 4'd0;
   localparam logic [3:0] STEP_HDR_LAST  = 4'd11;
   localparam logic [3:0] STEP_DATA      = 4'd12;
   localparam logic [3:0] STEP_STATUS    = 4'd13;

   // record signature "KEYSTORE"
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h4B;
         3'd1: b = 8'h45;
         3'd2: b = 8'h59;
         3'd3: b = 8'h53;
         3'd4: b = 8'h54;
         3'd5: b = 8'h4F;
         3'd6: b = 8'h52;
         default: b = 8'h45;
      endcase
      return b;
   endfunction

   // everything one accepted transaction has to put out
   typedef struct packed {
      logic        hdr;        // encode header burst ahead of the data byte
      logic [31:0] plen;       // length copied into the header
      logic        data_vld;
      logic [7:0]  data;
      logic        data_last;
      logic        stat_vld;
      logic [1:0]  code;
   } desc_type;

endpackage
`default_nettype wire

[rtl/keyed_xor_record_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_xor_record_framer
// frames byte records with a signature and length and masks them with a key
// ----------------------------------------------------------------------------
// Encode (mode 0): the first byte of a record is preceded by the 8-byte
// signature 4B 45 59 53 54 4F 52 45 and the little-endian 32-bit
// payload_length of that transaction; every payload byte leaves XORed with a
// key of key_length bytes used cyclically, and req_tlast ends the record.
// Decode (mode 1): the signature is checked, the length is gathered, payload
// bytes up to that length leave unmasked, excess is dropped, and the last
// input gives one status transaction (tuser high, tlast high). Data goes out
// before the status, so a consumer drops the record on a nonzero status.
// Rate: one input transaction per cycle unless the output stalls, for all items
// that give at most one result; the encode record start gives 13 results, a
// decode last byte with data gives 2, and the input waits for the last one to
// load. The limit is the single result register, which moves one transaction
// a cycle. Writing mode clears the record state; configure only while idle.
// ----------------------------------------------------------------------------
module keyed_xor_record_framer #(
   parameter int KEY_MAX_BYTES = kxrf_pkg::KEY_MAX_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [kxrf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                    csr_data,
   // input stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [39:0]                    req_tdata,  // in_byte[7:0], payload_length[39:8]
   input  wire logic                           req_tlast,  // in_last
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,  // out_byte[7:0], status_code[9:8], zero
   output logic                                rsp_tuser,  // is_status
   output logic                                rsp_tlast   // out_last
);
   import kxrf_pkg::*;

   localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

   // configuration registers
   logic                        mode_ff;
   logic [5:0]                  key_len_ff;
   logic [KEY_MAX_BYTES*8-1:0]  key_ff;

   // record state
   logic [32:0]                 pos_ff, pos_in;
   logic [KIDX_W-1:0]           kidx_ff, kidx_in;
   logic [31:0]                 decl_ff, decl_in;
   logic                        derr_ff, derr_in;

   // pending transaction and emit pointer
   desc_type                    desc_ff, desc_in;
   logic                        desc_vld_ff, desc_vld_in;
   logic [3:0]                  step_ff, step_in;

   // result register
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic [1:0]                  rsp_code_ff, rsp_code_in;
   logic                        rsp_user_ff, rsp_user_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        csr_wr;
   logic                        accept;
   logic                        out_load;
   logic                        step_final;

   logic [7:0]                  in_byte;
   logic                        in_last;
   logic [31:0]                 in_plen;

   // key stepping
   logic [5:0]                  eff_len;
   logic [KIDX_W:0]             kidx_inc;
   logic [KIDX_W-1:0]           kidx_next;
   logic [7:0]                  key_byte;

   logic [32:0]                 pos_sat;
   logic [32:0]                 pay_pos;
   logic [32:0]                 pay_total;
   desc_type                    new_desc;
   logic                        new_has;
   logic [3:0]                  new_step;

   assign in_byte = req_tdata[7:0];
   assign in_plen = req_tdata[39:8];
   assign in_last = req_tlast;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;

   // handshakes: result register frees whenever it is empty or being taken
   assign out_load   = desc_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign step_final = (step_ff == STEP_STATUS) || ((step_ff == STEP_DATA) && !desc_ff.stat_vld);
   assign req_tready = !desc_vld_ff || (out_load && step_final);
   assign accept     = req_tvalid && req_tready;

   // effective key length, clamped into 1..KEY_MAX_BYTES
   always_comb begin
      if (key_len_ff == 6'd0) begin
         eff_len = 6'd1;
      end else if (key_len_ff > 6'(KEY_MAX_BYTES)) begin
         eff_len = 6'(KEY_MAX_BYTES);
      end else begin
         eff_len = key_len_ff;
      end
   end

   assign key_byte = key_ff[kidx_ff*8 +: 8];
   assign kidx_inc = {1'b0, kidx_ff} + (KIDX_W+1)'(1);
   assign kidx_next = (7'(kidx_inc) >= 7'(eff_len)) ? '0 : kidx_inc[KIDX_W-1:0];

   assign pos_sat   = (pos_ff == '1) ? pos_ff : pos_ff + 33'd1;
   assign pay_pos   = pos_ff - 33'(HDR_BYTES);
   assign pay_total = pos_sat - 33'(HDR_BYTES);

   // per-transaction work: state update and what has to go out
   always_comb begin
      pos_in   = pos_ff;
      kidx_in  = kidx_ff;
      decl_in  = decl_ff;
      derr_in  = derr_ff;
      new_desc = '0;
      new_desc.plen = in_plen;
      new_desc.data = in_byte ^ key_byte;

      if (accept) begin
         pos_in = pos_sat;
         if (mode_ff == MODE_ENCODE) begin
            new_desc.hdr       = (pos_ff == 33'd0);
            new_desc.data_vld  = 1'b1;
            new_desc.data_last = in_last;
            kidx_in            = kidx_next;
         end else begin
            if (pos_ff < 33'(SIG_BYTES)) begin
               if (in_byte != sig_byte(pos_ff[2:0])) begin
                  derr_in = 1'b1;
               end
            end else if (pos_ff < 33'(HDR_BYTES)) begin
               // length field, little endian
               case (pos_ff[1:0])
                  2'd0:    decl_in[7:0]   = decl_ff[7:0]   | in_byte;
                  2'd1:    decl_in[15:8]  = decl_ff[15:8]  | in_byte;
                  2'd2:    decl_in[23:16] = decl_ff[23:16] | in_byte;
                  default: decl_in[31:24] = decl_ff[31:24] | in_byte;
               endcase
            end else if (!derr_ff && (pay_pos < {1'b0, decl_ff})) begin
               new_desc.data_vld = 1'b1;
               kidx_in           = kidx_next;
            end
            if (in_last) begin
               new_desc.stat_vld = 1'b1;
               if (pos_sat < 33'(HDR_BYTES)) begin
                  new_desc.code = STATUS_SHORT;
               end else if (derr_in) begin
                  new_desc.code = STATUS_BAD_SIG;
               end else if ({1'b0, decl_in} > pay_total) begin
                  new_desc.code = STATUS_OVERRUN;
               end else begin
                  new_desc.code = STATUS_OK;
               end
            end
         end
         // record ends on the last input in either mode
         if (in_last) begin
            pos_in  = '0;
            kidx_in = '0;
            decl_in = '0;
            derr_in = 1'b0;
         end
      end
   end

   assign new_has  = new_desc.hdr || new_desc.data_vld || new_desc.stat_vld;
   assign new_step = new_desc.hdr ? STEP_HDR_FIRST : (new_desc.data_vld ? STEP_DATA : STEP_STATUS);

   // pending transaction and emit pointer
   always_comb begin
      desc_in     = desc_ff;
      desc_vld_in = desc_vld_ff;
      step_in     = step_ff;
      if (out_load) begin
         if (step_final) begin
            desc_vld_in = 1'b0;
         end else if (step_ff == STEP_HDR_LAST) begin
            step_in = STEP_DATA;
         end else if (step_ff == STEP_DATA) begin
            step_in = STEP_STATUS;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
      if (accept) begin
         desc_in     = new_desc;
         desc_vld_in = new_has;
         step_in     = new_step;
      end
   end

   // result register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_code_in = rsp_code_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (out_load) begin
         rsp_vld_in  = 1'b1;
         rsp_code_in = STATUS_OK;
         rsp_user_in = 1'b0;
         rsp_last_in = 1'b0;
         if (step_ff < 4'(SIG_BYTES)) begin
            rsp_byte_in = sig_byte(step_ff[2:0]);
         end else if (step_ff <= STEP_HDR_LAST) begin
            rsp_byte_in = desc_ff.plen[{step_ff[1:0], 3'b000} +: 8];
         end else if (step_ff == STEP_DATA) begin
            rsp_byte_in = desc_ff.data;
            rsp_last_in = desc_ff.data_last;
         end else begin
            rsp_byte_in = 8'd0;
            rsp_code_in = desc_ff.code;
            rsp_user_in = 1'b1;
            rsp_last_in = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ENCODE;
         key_len_ff <= 6'd1;
         key_ff     <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_MODE:       mode_ff    <= csr_data[0];
            REG_KEY_LENGTH: key_len_ff <= csr_data[5:0];
            REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3: begin
               for (int j = 0; j < KEY_MAX_BYTES; j++) begin
                  if (csr_index == REG_KEY_WORD_0 + CSR_IDX_W'(j / 8)) begin
                     key_ff[j*8 +: 8] <= csr_data[(j % 8)*8 +: 8];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // record state, pending transaction and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         kidx_ff     <= '0;
         decl_ff     <= '0;
         derr_ff     <= 1'b0;
         desc_vld_ff <= 1'b0;
         step_ff     <= STEP_HDR_FIRST;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr && (csr_index == REG_MODE)) begin
            // mode write restarts the record
            pos_ff  <= '0;
            kidx_ff <= '0;
            decl_ff <= '0;
            derr_ff <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            kidx_ff <= kidx_in;
            decl_ff <= decl_in;
            derr_ff <= derr_in;
         end
         desc_vld_ff <= desc_vld_in;
         step_ff     <= step_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_code_ff <= rsp_code_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_code_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[sim/kxrf_record_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kxrf_record_checker
// watches the csr, request and response streams of the record framer, keeps
// its own copy of the framer state and compares every response transaction
// against the oldest predicted output byte or status
// ----------------------------------------------------------------------------
module kxrf_record_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [kxrf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_data,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [39:0]                    req_tdata,   // in_byte[7:0], payload_length[39:8]
   input  logic                           req_tlast,   // in_last
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [15:0]                    rsp_tdata,   // out_byte[7:0], status_code[9:8], zero
   input  logic                           rsp_tuser,   // is_status
   input  logic                           rsp_tlast,   // out_last
   output int                             fail_count,
   output int                             pending
);
   import kxrf_pkg::*;

   localparam int          KEY_MAX     = KEY_MAX_BYTES_DEF;
   localparam int          MAX_REPORTS = 40;
   localparam logic [32:0] POS_MAX     = '1;
   // "KEYSTORE", byte 0 in the low bits
   localparam logic [63:0] SIGNATURE   = 64'h4552_4F54_5359_454B;

   typedef struct packed {
      logic [7:0] data;
      logic       is_status;
      logic [1:0] code;
      logic       last;
   } framer_out_type;

   framer_out_type framer_out_q [$];
   framer_out_type oldest;

   // register copies
   logic        mode_r;
   logic [5:0]  key_len_r;
   logic [63:0] key_words_r [4];

   // record state
   logic [32:0] byte_pos;
   logic [4:0]  key_idx;
   logic [31:0] decl_len;
   logic [1:0]  dec_err;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < MAX_REPORTS)
         $display("%0t ns: mismatch on %s, got %0h want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic clear_record();
      byte_pos = '0;
      key_idx  = '0;
      decl_len = '0;
      dec_err  = STATUS_OK;
   endtask

   task automatic add_out(input logic [7:0] data, input logic is_status,
                          input logic [1:0] code, input logic last);
      framer_out_type r;
      r.data      = data;
      r.is_status = is_status;
      r.code      = code;
      r.last      = last;
      framer_out_q.insert(framer_out_q.size(), r);
   endtask

   function automatic int key_span();
      if (key_len_r == 6'd0) return 1;
      if (key_len_r > KEY_MAX) return KEY_MAX;
      return int'(key_len_r);
   endfunction

   // xor with the current key byte, then step the key cyclically
   function automatic logic [7:0] mask_byte(input logic [7:0] b);
      logic [7:0] k;
      int         nxt;
      k   = key_words_r[key_idx[4:3]][key_idx[2:0]*8 +: 8];
      nxt = key_idx + 1;
      if (nxt >= key_span()) nxt = 0;
      key_idx = nxt[4:0];
      return b ^ k;
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      case (idx)
         REG_MODE: begin
            mode_r = val[0];
            clear_record();
         end
         REG_KEY_LENGTH: key_len_r      = val[5:0];
         REG_KEY_WORD_0: key_words_r[0] = val;
         REG_KEY_WORD_1: key_words_r[1] = val;
         REG_KEY_WORD_2: key_words_r[2] = val;
         REG_KEY_WORD_3: key_words_r[3] = val;
         default: ;
      endcase
   endtask

   task automatic run_framer(input logic [7:0] b, input logic last, input logic [31:0] plen);
      logic [32:0] total;
      logic [1:0]  code;
      if (mode_r == MODE_ENCODE) begin
         if (byte_pos == '0) begin
            for (int i = 0; i < SIG_BYTES; i++) add_out(SIGNATURE[i*8 +: 8], 1'b0, STATUS_OK, 1'b0);
            for (int i = 0; i < 4; i++) add_out(plen[i*8 +: 8], 1'b0, STATUS_OK, 1'b0);
         end
         add_out(mask_byte(b), 1'b0, STATUS_OK, last);
         if (byte_pos != POS_MAX) byte_pos = byte_pos + 33'd1;
         if (last) clear_record();
      end else begin
         if (byte_pos < SIG_BYTES) begin
            if (b != SIGNATURE[byte_pos[2:0]*8 +: 8]) dec_err = STATUS_BAD_SIG;
         end else if (byte_pos < HDR_BYTES) begin
            decl_len = decl_len | ({24'd0, b} << (8 * byte_pos[1:0]));
         end else if (dec_err == STATUS_OK && (byte_pos - 33'(HDR_BYTES)) < {1'b0, decl_len}) begin
            add_out(mask_byte(b), 1'b0, STATUS_OK, 1'b0);
         end
         if (byte_pos != POS_MAX) byte_pos = byte_pos + 33'd1;
         if (last) begin
            total = byte_pos;
            if (total < HDR_BYTES) code = STATUS_SHORT;
            else if (dec_err != STATUS_OK) code = STATUS_BAD_SIG;
            else if ({1'b0, decl_len} > total - 33'(HDR_BYTES)) code = STATUS_OVERRUN;
            else code = STATUS_OK;
            add_out(8'h00, 1'b1, code, 1'b1);
            clear_record();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_r    = MODE_ENCODE;
         key_len_r = 6'd1;
         for (int i = 0; i < 4; i++) key_words_r[i] = '0;
         clear_record();
         framer_out_q.delete();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         // predict before comparing so a same-edge result still meets its entry
         if (req_tvalid && req_tready) run_framer(req_tdata[7:0], req_tlast, req_tdata[39:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (framer_out_q.size() == 0) begin
               report_mismatch("unpredicted result", {15'd0, rsp_tuser, rsp_tdata}, 32'd0);
            end else begin
               oldest = framer_out_q.pop_front();
               if (rsp_tdata[7:0] !== oldest.data)
                  report_mismatch("out_byte", 32'(rsp_tdata[7:0]), 32'(oldest.data));
               if (rsp_tdata[9:8] !== oldest.code)
                  report_mismatch("status_code", 32'(rsp_tdata[9:8]), 32'(oldest.code));
               if (rsp_tdata[15:10] !== 6'd0)
                  report_mismatch("tdata pad", 32'(rsp_tdata[15:10]), 32'd0);
               if (rsp_tuser !== oldest.is_status)
                  report_mismatch("is_status", 32'(rsp_tuser), 32'(oldest.is_status));
               if (rsp_tlast !== oldest.last)
                  report_mismatch("out_last", 32'(rsp_tlast), 32'(oldest.last));
            end
         end
      end
      pending = framer_out_q.size();
   end

endmodule

[sim/tb_keyed_xor_record_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_xor_record_framer
// stimulus and verdict for the keyed xor record framer
// ----------------------------------------------------------------------------
// A short directed run covers field extremes, key length clamping, a key
// change and a mode write inside an open record, and short and good decode
// records. Random phases follow, most with new register writes: encode
// records of random size and declared length, and decode records that are
// mostly well formed (good, excess, overrun) with short, bad signature and
// noise records mixed in. The sender works in bursts, the receiver stalls on
// a pattern of its own, and one long receiver hold fills the block up.
// The checker module predicts and compares; this top only drives.
// ----------------------------------------------------------------------------
module tb_keyed_xor_record_framer;
   import kxrf_pkg::*;

   localparam int CYCLE_LIMIT      = 300000;
   localparam int SETTLE_CYCLES    = 16;     // block may still chew on a silent byte
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DIRECTED_ITEMS   = 24;
   localparam int RANDOM_ITEMS     = 400;

   // spare register indexes, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   typedef enum {REC_OK, REC_EXCESS, REC_OVERRUN, REC_SHORT, REC_BAD_SIG, REC_NOISE} rec_kind_type;
   typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [39:0]          req_tdata;   // in_byte[7:0], payload_length[39:8]
   logic                 req_tlast;   // in_last
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;   // out_byte[7:0], status_code[9:8], zero
   logic                 rsp_tuser;   // is_status
   logic                 rsp_tlast;   // out_last

   int   fail_count;
   int   pending_results;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   burst_left  = 1;
   bit   gaps_on     = 1'b1;
   bit   hold_rsp    = 1'b0;
   // handshakes seen at the last rising edge
   logic req_fire    = 1'b0;
   logic csr_fire    = 1'b0;

   always #5 clock = ~clock;

   keyed_xor_record_framer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   kxrf_record_checker record_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending_results)
   );

   // sample handshakes with the values from just before the edge
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      csr_fire <= csr_valid && csr_ready;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: stall style is redrawn once its random run is spent, plus one long hold
   initial begin
      int           style_left;
      int           hold_left;
      rx_style_type style;
      rsp_tready = 1'b0;
      style_left = 0;
      hold_left  = 0;
      style      = RX_OPEN;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_rsp  = 1'b0;
         end
         if (style_left == 0) begin
            case ($urandom_range(0, 3))
               0:       style = RX_OPEN;
               1:       style = RX_LIGHT;
               2:       style = RX_HEAVY;
               default: style = RX_PERIODIC;
            endcase
            style_left = $urandom_range(64, 256);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (style)
               RX_OPEN:  rsp_tready = 1'b1;
               RX_LIGHT: rsp_tready = ($urandom_range(0, 3) != 0);
               RX_HEAVY: rsp_tready = ($urandom_range(0, 3) == 0);
               default:  rsp_tready = (cycle_count % 5 < 3);
            endcase
         end
      end
   end

   // one csr transaction, entered and left at a falling edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      while (!csr_fire) @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one request transaction; valid stays high into the next item of a burst
   task automatic push_item(input logic [7:0] b, input logic last, input logic [31:0] plen);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = {plen, b};
      req_tlast  = last;
      @(negedge clock);
      while (!req_fire) @(negedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // sender pause until every predicted result has come back
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_key_word();
      logic [63:0] w;
      case ($urandom_range(0, 5))
         0:       w = '0;
         1:       w = '1;
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   // any value differing from the current low key word will do
   function automatic logic [63:0] record_key_guess();
      return {$urandom, $urandom};
   endfunction

   // clamped values 0 and above 32 show up often
   function automatic logic [5:0] pick_key_length();
      logic [5:0] n;
      case ($urandom_range(0, 10))
         0:       n = 6'd0;
         1:       n = 6'd1;
         2:       n = 6'd2;
         3:       n = 6'd3;
         4:       n = 6'd7;
         5:       n = 6'd8;
         6:       n = 6'd31;
         7:       n = 6'd32;
         8:       n = 6'd33;
         9:       n = 6'd63;
         default: n = 6'($urandom_range(0, 63));
      endcase
      return n;
   endfunction

   function automatic rec_kind_type pick_kind(input int code);
      case (code)
         1:       return REC_EXCESS;
         2:       return REC_OVERRUN;
         3:       return REC_SHORT;
         4:       return REC_BAD_SIG;
         5:       return REC_NOISE;
         default: return REC_OK;
      endcase
   endfunction

   task automatic send_encode_record(input int n, input logic [31:0] plen, input bit leave_open);
      logic [7:0]  b;
      logic [31:0] other;
      for (int i = 0; i < n; i++) begin
         b     = 8'($urandom);
         other = $urandom;
         push_item(b, (i == n - 1) && !leave_open, (i == 0) ? plen : other);
      end
   endtask

   // builds a stored record of the given kind and streams it
   task automatic send_decode_record(input rec_kind_type kind, input bit leave_open);
      logic [7:0]  rec [$];
      logic [7:0]  b;
      logic [31:0] decl;
      logic [31:0] junk;
      int          payload_n;
      int          send_n;
      int          bad_at;
      payload_n = $urandom_range(0, 10);
      decl      = payload_n;
      case (kind)
         REC_EXCESS: begin
            payload_n = $urandom_range(1, 10);
            decl      = $urandom_range(0, payload_n - 1);
         end
         REC_OVERRUN: begin
            payload_n = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) decl = $urandom;
            else decl = payload_n + $urandom_range(1, 4);
         end
         default: ;
      endcase
      for (int i = 0; i < SIG_BYTES; i++) rec.insert(rec.size(), sig_byte(i[2:0]));
      for (int i = 0; i < 4; i++) rec.insert(rec.size(), decl[i*8 +: 8]);
      for (int i = 0; i < payload_n; i++) begin
         b = 8'($urandom);
         rec.insert(rec.size(), b);
      end
      // short records sometimes carry a broken signature too
      if (kind == REC_BAD_SIG || (kind == REC_SHORT && $urandom_range(0, 1) == 1)) begin
         bad_at      = $urandom_range(0, SIG_BYTES - 1);
         b           = 8'($urandom_range(1, 255));
         rec[bad_at] = rec[bad_at] ^ b;
      end
      if (kind == REC_NOISE) begin
         rec.delete();
         repeat ($urandom_range(1, 20)) begin
            b = 8'($urandom);
            rec.insert(rec.size(), b);
         end
      end
      send_n = (kind == REC_SHORT) ? $urandom_range(1, HDR_BYTES - 1) : rec.size();
      for (int i = 0; i < send_n; i++) begin
         junk = $urandom;
         push_item(rec[i], (i == send_n - 1) && !leave_open, junk);
      end
   endtask

   initial begin
      logic [63:0]  word;
      logic [2:0]   word_reg;
      logic [31:0]  plen;
      logic         run_mode;
      rec_kind_type kind;
      int           phase;
      int           n_rec;
      int           n;
      int           decode_records;
      bit           leave_open;

      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---------------- directed ----------------
      write_reg(REG_KEY_WORD_0, pick_key_word());
      write_reg(REG_KEY_WORD_1, pick_key_word());
      write_reg(REG_KEY_WORD_2, pick_key_word());
      write_reg(REG_KEY_WORD_3, pick_key_word());
      write_reg(REG_SPARE_6, {$urandom, $urandom});
      write_reg(REG_SPARE_7, {$urandom, $urandom});
      write_reg(REG_KEY_LENGTH, 64'd3);
      write_reg(REG_MODE, {63'd0, MODE_ENCODE});
      // one-byte record declaring length one
      push_item(8'h00, 1'b1, 32'd1);
      // header length copied as given, not matched to the payload
      push_item(8'hFF, 1'b0, 32'hFFFF_FFFF);
      push_item(8'hFF, 1'b1, 32'd0);
      wait_idle();
      // key length zero acts as one
      write_reg(REG_KEY_LENGTH, 64'd0);
      push_item(8'h5A, 1'b0, 32'd2);
      push_item(8'hA5, 1'b0, $urandom);
      wait_idle();
      // key change inside an open record
      write_reg(REG_KEY_WORD_0, ~record_key_guess());
      push_item(8'h3C, 1'b1, $urandom);
      // record left open, then a mode write drops it
      push_item(8'h81, 1'b0, $urandom);
      push_item(8'h7E, 1'b0, $urandom);
      wait_idle();
      // oversized key length clamps to the maximum
      write_reg(REG_KEY_LENGTH, 64'd63);
      write_reg(REG_MODE, {63'd0, MODE_DECODE});
      // record that ends inside the signature
      for (int i = 0; i < 3; i++) push_item(sig_byte(i[2:0]), i == 2, $urandom);
      // good record declaring one payload byte
      for (int i = 0; i < SIG_BYTES; i++) push_item(sig_byte(i[2:0]), 1'b0, $urandom);
      push_item(8'h01, 1'b0, $urandom);
      push_item(8'h00, 1'b0, $urandom);
      push_item(8'h00, 1'b0, $urandom);
      push_item(8'h00, 1'b0, $urandom);
      push_item(8'hFF, 1'b1, $urandom);

      // ---------------- random phases ----------------
      phase          = 0;
      decode_records = 0;
      run_mode       = MODE_DECODE;
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         wait_idle();
         // new register setting, mode write skipped now and then so records can span phases
         if (phase < 2 || $urandom_range(0, 3) != 0) begin
            if (phase == 0) run_mode = MODE_ENCODE;
            else if (phase == 1) run_mode = MODE_DECODE;
            else run_mode = 1'($urandom_range(0, 1));
            word    = {$urandom, $urandom};
            word[0] = run_mode;
            write_reg(REG_MODE, word);
         end
         if ($urandom_range(0, 1) == 1) begin
            word      = {$urandom, $urandom};
            word[5:0] = pick_key_length();
            write_reg(REG_KEY_LENGTH, word);
         end
         for (int w = 0; w < 4; w++) begin
            if ($urandom_range(0, 1) == 1) begin
               case (w)
                  0:       word_reg = REG_KEY_WORD_0;
                  1:       word_reg = REG_KEY_WORD_1;
                  2:       word_reg = REG_KEY_WORD_2;
                  default: word_reg = REG_KEY_WORD_3;
               endcase
               write_reg(word_reg, pick_key_word());
            end
         end

         // first phase: receiver holds off while the sender keeps pushing encode starts
         if (phase == 0) begin
            gaps_on  = 1'b0;
            hold_rsp = 1'b1;
            n_rec    = 4;
         end else begin
            gaps_on = ($urandom_range(0, 3) != 0);
            n_rec   = $urandom_range(1, 4);
         end

         for (int r = 0; r < n_rec; r++) begin
            leave_open = (r == n_rec - 1) && ($urandom_range(0, 7) == 0);
            if (run_mode == MODE_ENCODE) begin
               n = $urandom_range(1, 16);
               case ($urandom_range(0, 3))
                  0:       plen = n;
                  1:       plen = $urandom;
                  2:       plen = 32'd1;
                  default: plen = 32'hFFFF_FFFF;
               endcase
               send_encode_record(n, plen, leave_open);
            end else begin
               // every record kind once, then mostly well formed ones
               if (decode_records < 6) kind = pick_kind(decode_records);
               else begin
                  n    = $urandom_range(0, 9);
                  kind = pick_kind(n > 5 ? 0 : n);
               end
               send_decode_record(kind, leave_open);
               decode_records++;
            end
         end
         phase++;
      end

      wait_idle();
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

[keyed_xor_record_framer.f]
rtl/kxrf_pkg.sv
rtl/keyed_xor_record_framer.sv
sim/kxrf_record_checker.sv
sim/tb_keyed_xor_record_framer.sv
